// ----- design/plgs_pkg.sv -----
// Shared widths, register codes and types for the piecewise-linear gain schedule.
package plgs_pkg;

    localparam int POINTS          = 7;
    localparam int NUM_POINT_REGS  = 6;
    localparam int IDX_W           = $clog2(POINTS);

    localparam int ANGLE_W         = 15;
    localparam int GAIN_W          = 16;
    localparam int SEG_W           = 3;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 31;

    localparam int NUM_W           = GAIN_W + ANGLE_W;
    localparam int QUO_W           = GAIN_W;
    localparam int DIV_STAGES      = QUO_W;

    localparam logic [GAIN_W-1:0] BASE_GAIN_RESET = GAIN_W'(1280);

    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BASE_GAIN     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_POINT1        = CFG_IDX_W'(2);

    typedef struct packed {
        logic [IDX_W-1:0]                  count;
        logic [POINTS-1:0][ANGLE_W-1:0]    angle;
        logic [POINTS-1:0][GAIN_W-1:0]     gain;
    } plgs_table_t;

    typedef struct packed {
        logic [NUM_W-1:0]   num;
        logic [ANGLE_W-1:0] span;
        logic [GAIN_W-1:0]  g0;
        logic               neg;
        logic               hold;
    } plgs_div_in_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] rem;
        logic [QUO_W-1:0]   work;
        logic [ANGLE_W-1:0] span;
        logic [GAIN_W-1:0]  g0;
        logic               neg;
        logic               hold;
    } plgs_div_stage_t;

    typedef struct packed {
        logic [QUO_W-1:0]  quo;
        logic [GAIN_W-1:0] g0;
        logic              neg;
        logic              hold;
    } plgs_div_out_t;

endpackage

// ----- design/piecewise_linear_gain_schedule_core.sv -----
// Top level of the piecewise-linear gain schedule: stage wiring and output register.
//
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-----------------------------------
// angle    | angle_valid / angle_stall | tilt_angle  (Q7.8, 15 bits)
// gain     | gain_valid  / gain_stall  | gain_out    (Q8.8, 16 bits)
// cfg      | cfg_valid   / cfg_ready   | cfg_index (3 bits), cfg_data (31 bits)
//
// Unless stalled, an angle transaction is taken every cycle; each yields exactly one gain
// transaction after three set-up stages (segment search, span and slope, multiply),
// sixteen divider stages producing one quotient bit each, and the output register that
// applies the signed correction to the lower gain. Reset is asynchronous and active low;
// it empties the pipeline and restores the configuration defaults. Each stage holds while
// the next is full and blocked, so a gain stall fills bubbles before angle_stall rises.
module piecewise_linear_gain_schedule_core (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             angle_valid,
    output logic                             angle_stall,
    input  logic [plgs_pkg::ANGLE_W-1:0]     tilt_angle,

    output logic                             gain_valid,
    input  logic                             gain_stall,
    output logic [plgs_pkg::GAIN_W-1:0]      gain_out,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [plgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [plgs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    plgs_pkg::plgs_table_t     tbl;
    plgs_pkg::plgs_div_in_t    div_in;
    plgs_pkg::plgs_div_out_t   div_out;
    logic                      sel_ready;
    logic                      div_in_valid;
    logic                      div_in_ready;
    logic                      div_out_valid;
    logic                      out_en;

    logic                      out_valid_reg;
    logic [plgs_pkg::GAIN_W-1:0] gain_reg;
    logic [plgs_pkg::GAIN_W-1:0] gain_next;

    plgs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tbl       (tbl)
    );

    plgs_select u_select (
        .clk         (clk),
        .rst_n       (rst_n),
        .tbl         (tbl),
        .angle_valid (angle_valid),
        .tilt_angle  (tilt_angle),
        .angle_ready (sel_ready),
        .div_valid   (div_in_valid),
        .div_in      (div_in),
        .div_ready   (div_in_ready)
    );

    plgs_divider u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (div_in_valid),
        .up_data    (div_in),
        .up_ready   (div_in_ready),
        .down_valid (div_out_valid),
        .down_data  (div_out),
        .down_ready (out_en)
    );

    assign angle_stall = !sel_ready;

    // The output register takes a new result when empty or when its current
    // transaction is being taken.
    assign out_en = !out_valid_reg || !gain_stall;

    // The quotient never exceeds the gain difference, so the sum stays in range.
    always_comb
    begin
        if (div_out.hold)
        begin
            gain_next = div_out.g0;
        end
        else if (div_out.neg)
        begin
            gain_next = div_out.g0 - div_out.quo;
        end
        else
        begin
            gain_next = div_out.g0 + div_out.quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            gain_reg <= gain_next;
        end
    end

    assign gain_valid = out_valid_reg;
    assign gain_out   = gain_reg;

`ifndef SYNTH
    // With the output register empty every stage can advance, so no stall upstream.
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !angle_stall)
        else $error("angle stalled while output register empty");
`endif

endmodule

// ----- design/plgs_cfg_regs.sv -----
// Configuration register file holding the breakpoint table.
module plgs_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [plgs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [plgs_pkg::CFG_DATA_W-1:0]    cfg_data,
    output plgs_pkg::plgs_table_t              tbl
);

    logic [plgs_pkg::SEG_W-1:0]  segment_count_reg;
    logic [plgs_pkg::GAIN_W-1:0] base_gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segment_count_reg <= '0;
            base_gain_reg     <= plgs_pkg::BASE_GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == plgs_pkg::REG_SEGMENT_COUNT)
            begin
                segment_count_reg <= cfg_data[plgs_pkg::SEG_W-1:0];
            end
            if (cfg_index == plgs_pkg::REG_BASE_GAIN)
            begin
                base_gain_reg <= cfg_data[plgs_pkg::GAIN_W-1:0];
            end
        end
    end

    // Counts beyond the table are clamped to its last entry.
    assign tbl.count = (32'(segment_count_reg) > plgs_pkg::POINTS - 1) ?
                       plgs_pkg::IDX_W'(plgs_pkg::POINTS - 1) :
                       plgs_pkg::IDX_W'(segment_count_reg);

    assign tbl.angle[0] = '0;
    assign tbl.gain[0]  = base_gain_reg;

    for (genvar p = 1; p < plgs_pkg::POINTS; p++)
    begin : g_point
        if (p <= plgs_pkg::NUM_POINT_REGS)
        begin : g_reg
            logic [plgs_pkg::ANGLE_W-1:0] angle_reg;
            logic [plgs_pkg::GAIN_W-1:0]  gain_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    angle_reg <= '0;
                    gain_reg  <= '0;
                end
                else if (cfg_valid &&
                         (cfg_index == plgs_pkg::REG_POINT1 + plgs_pkg::CFG_IDX_W'(p - 1)))
                begin
                    angle_reg <= cfg_data[plgs_pkg::GAIN_W +: plgs_pkg::ANGLE_W];
                    gain_reg  <= cfg_data[plgs_pkg::GAIN_W-1:0];
                end
            end

            assign tbl.angle[p] = angle_reg;
            assign tbl.gain[p]  = gain_reg;
        end
        else
        begin : g_zero
            // Breakpoints with no register behind them read as zero.
            assign tbl.angle[p] = '0;
            assign tbl.gain[p]  = '0;
        end
    end

endmodule

// ----- design/plgs_select.sv -----
// Segment search, span and slope set-up, and slope-by-offset product stages.
module plgs_select (
    input  logic                             clk,
    input  logic                             rst_n,
    input  plgs_pkg::plgs_table_t            tbl,
    input  logic                             angle_valid,
    input  logic [plgs_pkg::ANGLE_W-1:0]     tilt_angle,
    output logic                             angle_ready,
    output logic                             div_valid,
    output plgs_pkg::plgs_div_in_t           div_in,
    input  logic                             div_ready
);

    logic [plgs_pkg::IDX_W-1:0]   sel;
    logic [plgs_pkg::ANGLE_W-1:0] a0;
    logic [plgs_pkg::ANGLE_W-1:0] a1;
    logic [plgs_pkg::GAIN_W-1:0]  g0;
    logic [plgs_pkg::GAIN_W-1:0]  g1;

    logic                         en1;
    logic                         en2;
    logic                         en3;

    logic                         s1_valid_reg;
    logic [plgs_pkg::ANGLE_W-1:0] s1_a_reg;
    logic [plgs_pkg::ANGLE_W-1:0] s1_a0_reg;
    logic [plgs_pkg::ANGLE_W-1:0] s1_a1_reg;
    logic [plgs_pkg::GAIN_W-1:0]  s1_g0_reg;
    logic [plgs_pkg::GAIN_W-1:0]  s1_g1_reg;
    logic                         s1_top_reg;

    logic                         s2_valid_reg;
    logic [plgs_pkg::ANGLE_W-1:0] s2_span_reg;
    logic [plgs_pkg::ANGLE_W-1:0] s2_da_reg;
    logic [plgs_pkg::GAIN_W-1:0]  s2_mag_reg;
    logic [plgs_pkg::GAIN_W-1:0]  s2_g0_reg;
    logic                         s2_neg_reg;
    logic                         s2_hold_reg;

    logic                         s3_valid_reg;
    plgs_pkg::plgs_div_in_t       s3_reg;

    assign en3         = !s3_valid_reg || div_ready;
    assign en2         = !s2_valid_reg || en3;
    assign en1         = !s1_valid_reg || en2;
    assign angle_ready = en1;

    // Highest used breakpoint at or below the angle. Breakpoint 0 always matches.
    always_comb
    begin
        sel = '0;
        a0  = '0;
        a1  = '0;
        g0  = '0;
        g1  = '0;
        for (int i = 0; i < plgs_pkg::POINTS; i++)
        begin
            int nxt;
            nxt = (i < plgs_pkg::POINTS - 1) ? i + 1 : i;
            if ((plgs_pkg::IDX_W'(i) <= tbl.count) && (tilt_angle >= tbl.angle[i]))
            begin
                sel = plgs_pkg::IDX_W'(i);
                a0  = tbl.angle[i];
                g0  = tbl.gain[i];
                a1  = tbl.angle[nxt];
                g1  = tbl.gain[nxt];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= angle_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_a_reg   <= tilt_angle;
            s1_a0_reg  <= a0;
            s1_a1_reg  <= a1;
            s1_g0_reg  <= g0;
            s1_g1_reg  <= g1;
            s1_top_reg <= (sel == tbl.count);
        end
        if (en2)
        begin
            s2_span_reg <= s1_a1_reg - s1_a0_reg;
            s2_da_reg   <= s1_a_reg - s1_a0_reg;
            s2_neg_reg  <= (s1_g1_reg < s1_g0_reg);
            s2_mag_reg  <= (s1_g1_reg < s1_g0_reg) ? s1_g0_reg - s1_g1_reg
                                                   : s1_g1_reg - s1_g0_reg;
            s2_g0_reg   <= s1_g0_reg;
            s2_hold_reg <= s1_top_reg || (s1_a1_reg <= s1_a0_reg);
        end
        if (en3)
        begin
            s3_reg.num  <= s2_hold_reg ? '0 : s2_mag_reg * s2_da_reg;
            s3_reg.span <= s2_span_reg;
            s3_reg.g0   <= s2_g0_reg;
            s3_reg.neg  <= s2_neg_reg;
            s3_reg.hold <= s2_hold_reg;
        end
    end

    assign div_valid = s3_valid_reg;
    assign div_in    = s3_reg;

`ifndef SYNTH
    // Below the top breakpoint the upper breakpoint lies strictly above the angle.
    a_upper_above: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_top_reg) |-> (s1_a1_reg > s1_a_reg))
        else $error("upper breakpoint not above angle");

    // The divider needs a quotient that fits its width.
    a_quotient_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !s3_reg.hold) |->
            (s3_reg.num[plgs_pkg::NUM_W-1 -: plgs_pkg::ANGLE_W] < s3_reg.span))
        else $error("dividend too large for span");
`endif

endmodule

// ----- design/plgs_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module plgs_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    input  plgs_pkg::plgs_div_in_t      up_data,
    output logic                        up_ready,
    output logic                        down_valid,
    output plgs_pkg::plgs_div_out_t     down_data,
    input  logic                        down_ready
);

    plgs_pkg::plgs_div_stage_t st_reg [plgs_pkg::DIV_STAGES];
    plgs_pkg::plgs_div_stage_t st_in  [plgs_pkg::DIV_STAGES];
    logic                      v_reg  [plgs_pkg::DIV_STAGES];
    logic                      v_in   [plgs_pkg::DIV_STAGES];
    logic                      en     [plgs_pkg::DIV_STAGES+1];

    function automatic plgs_pkg::plgs_div_stage_t div_step(plgs_pkg::plgs_div_stage_t s);
        plgs_pkg::plgs_div_stage_t r;
        logic [plgs_pkg::ANGLE_W:0] t;
        logic                       ge;
        r    = s;
        t    = {s.rem, s.work[plgs_pkg::QUO_W-1]};
        ge   = (t >= {1'b0, s.span});
        r.rem  = ge ? plgs_pkg::ANGLE_W'(t - {1'b0, s.span}) : t[plgs_pkg::ANGLE_W-1:0];
        r.work = {s.work[plgs_pkg::QUO_W-2:0], ge};
        return r;
    endfunction

    assign en[plgs_pkg::DIV_STAGES] = down_ready;
    assign up_ready = en[0];

    assign st_in[0].rem  = up_data.num[plgs_pkg::NUM_W-1 -: plgs_pkg::ANGLE_W];
    assign st_in[0].work = up_data.num[plgs_pkg::QUO_W-1:0];
    assign st_in[0].span = up_data.span;
    assign st_in[0].g0   = up_data.g0;
    assign st_in[0].neg  = up_data.neg;
    assign st_in[0].hold = up_data.hold;
    assign v_in[0]       = up_valid;

    for (genvar k = 0; k < plgs_pkg::DIV_STAGES; k++)
    begin : g_stage
        if (k > 0)
        begin : g_link
            assign st_in[k] = st_reg[k-1];
            assign v_in[k]  = v_reg[k-1];
        end

        assign en[k] = !v_reg[k] || en[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                v_reg[k] <= v_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                st_reg[k] <= div_step(st_in[k]);
            end
        end
    end

    assign down_valid     = v_reg[plgs_pkg::DIV_STAGES-1];
    assign down_data.quo  = st_reg[plgs_pkg::DIV_STAGES-1].work;
    assign down_data.g0   = st_reg[plgs_pkg::DIV_STAGES-1].g0;
    assign down_data.neg  = st_reg[plgs_pkg::DIV_STAGES-1].neg;
    assign down_data.hold = st_reg[plgs_pkg::DIV_STAGES-1].hold;

`ifndef SYNTH
    // A restoring step always leaves a remainder below the divisor.
    a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[plgs_pkg::DIV_STAGES-1] && !st_reg[plgs_pkg::DIV_STAGES-1].hold) |->
            (st_reg[plgs_pkg::DIV_STAGES-1].rem < st_reg[plgs_pkg::DIV_STAGES-1].span))
        else $error("divider remainder not below span");
`endif

endmodule

// ----- dv/gain_schedule_checker.sv -----
`timescale 1ns / 100ps
// Checker for the gain schedule: mirrors the breakpoint registers, predicts each gain and compares.
module gain_schedule_checker (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             angle_valid,
    input  logic                             angle_stall,
    input  logic [plgs_pkg::ANGLE_W-1:0]     tilt_angle,

    input  logic                             gain_valid,
    input  logic                             gain_stall,
    input  logic [plgs_pkg::GAIN_W-1:0]      gain_out,

    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [plgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [plgs_pkg::CFG_DATA_W-1:0]  cfg_data,

    output int                               error_count,
    output int                               outstanding
);
    import plgs_pkg::*;

    logic [SEG_W-1:0]   seg_sel;
    logic [ANGLE_W-1:0] knot_angle [POINTS];
    logic [GAIN_W-1:0]  knot_gain  [POINTS];
    logic [GAIN_W-1:0]  pending_gains [$];
    logic [GAIN_W-1:0]  want;
    int                 slot;

    // Breakpoint 0 is pinned at angle zero, so its angle entry is never written.
    function automatic logic [GAIN_W-1:0] lookup_gain(input logic [ANGLE_W-1:0] tilt);
        int     top;
        int     lo;
        longint a0;
        longint a1;
        longint g0;
        longint g1;
        longint rise;
        top = (int'(seg_sel) > POINTS - 1) ? POINTS - 1 : int'(seg_sel);
        lo = 0;
        // The highest breakpoint at or below the angle wins, ordered or not.
        for (int i = 1; i <= top; i++)
            if (tilt >= knot_angle[i])
                lo = i;
        if (lo == top)
            return knot_gain[lo];
        a0 = longint'(knot_angle[lo]);
        a1 = longint'(knot_angle[lo + 1]);
        g0 = longint'(knot_gain[lo]);
        g1 = longint'(knot_gain[lo + 1]);
        if (a1 <= a0)
            return knot_gain[lo];
        // Signed division truncates toward zero, which is what the slope needs.
        rise = (g1 - g0) * (longint'(tilt) - a0) / (a1 - a0);
        return GAIN_W'(g0 + rise);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_sel <= '0;
            for (int i = 1; i < POINTS; i++)
            begin
                knot_angle[i] <= '0;
                knot_gain[i]  <= '0;
            end
            knot_angle[0] <= '0;
            knot_gain[0]  <= BASE_GAIN_RESET;
            pending_gains.delete();
            error_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SEGMENT_COUNT: seg_sel <= cfg_data[SEG_W-1:0];
                    REG_BASE_GAIN:     knot_gain[0] <= cfg_data[GAIN_W-1:0];
                    default:
                    begin
                        slot = int'(cfg_index) - int'(REG_POINT1) + 1;
                        if (slot < POINTS)
                        begin
                            knot_angle[slot] <= cfg_data[CFG_DATA_W-1:GAIN_W];
                            knot_gain[slot]  <= cfg_data[GAIN_W-1:0];
                        end
                    end
                endcase
            end

            // Retire before queuing so an empty queue never matches its own new entry.
            if (gain_valid && !gain_stall)
            begin
                if (pending_gains.size() == 0)
                begin
                    $error("gain_out: expected no transaction, actual %0d", gain_out);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = pending_gains.pop_front();
                    if (gain_out !== want)
                    begin
                        $error("gain_out: expected %0d, actual %0d", want, gain_out);
                        error_count <= error_count + 1;
                    end
                end
            end

            if (angle_valid && !angle_stall)
                pending_gains.push_back(lookup_gain(tilt_angle));

            outstanding <= pending_gains.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the gain schedule: table set-up, angle stimulus, stall patterns and verdict.
module tb;
    import plgs_pkg::*;

    localparam int RANDOM_PHASES   = 9;
    localparam int ITEMS_PER_PHASE = 212;
    localparam int FULL_SCALE      = 23040;            // 90 degrees in Q7.8
    localparam int ANGLE_MAX       = (1 << ANGLE_W) - 1;
    localparam int GAIN_MAX        = (1 << GAIN_W) - 1;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CALM_PHASE      = 4;
    localparam int HOLD_PHASE      = 7;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  angle_valid = 1'b0;
    logic                  angle_stall;
    logic [ANGLE_W-1:0]    tilt_angle  = '0;
    logic                  gain_valid;
    logic                  gain_stall  = 1'b0;
    logic [GAIN_W-1:0]     gain_out;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    // While calm is set neither side idles, so the pipeline runs at full rate.
    logic                  calm        = 1'b0;
    int                    error_count;
    int                    outstanding;

    // The table that the stimulus is about to load and then aims its angles at.
    logic [SEG_W-1:0]      plan_count;
    logic [GAIN_W-1:0]     plan_base;
    logic [ANGLE_W-1:0]    plan_angle [1:NUM_POINT_REGS];
    logic [GAIN_W-1:0]     plan_gain  [1:NUM_POINT_REGS];

    // Angles that sit on, just beside and between the directed breakpoints.
    int ordered_probes [13] = '{0, 1, 3839, 3840, 3841, 5760, 7679, 7680, 11520,
                                17000, 23040, 32766, 32767};
    int unordered_probes [10] = '{0, 1999, 2000, 4999, 5000, 9999, 19999, 20000,
                                  23040, 32767};

    piecewise_linear_gain_schedule_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .angle_valid (angle_valid),
        .angle_stall (angle_stall),
        .tilt_angle  (tilt_angle),
        .gain_valid  (gain_valid),
        .gain_stall  (gain_stall),
        .gain_out    (gain_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    gain_schedule_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .angle_valid (angle_valid),
        .angle_stall (angle_stall),
        .tilt_angle  (tilt_angle),
        .gain_valid  (gain_valid),
        .gain_stall  (gain_stall),
        .gain_out    (gain_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The gain side stalls in short bursts, now and then in a burst long enough to
    // fill the whole pipeline and push back on the angle side.
    always
    begin
        @(posedge clk);
        if (calm)
            gain_stall <= 1'b0;
        else
        begin
            gain_stall <= 1'b1;
            repeat (($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 5))
                @(posedge clk);
            gain_stall <= 1'b0;
            repeat ($urandom_range(1, 10))
                @(posedge clk);
        end
    end

    // One angle transaction, then possibly a gap. Valid stays high straight into the
    // next transaction when there is no gap.
    task automatic send_angle(input int angle_q8);
        angle_valid <= 1'b1;
        tilt_angle  <= ANGLE_W'(angle_q8);
        @(posedge clk);
        while (angle_stall)
            @(posedge clk);
        if (!calm && $urandom_range(99) < 25)
        begin
            angle_valid <= 1'b0;
            repeat (($urandom_range(19) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 3))
                @(posedge clk);
        end
    endtask

    // Stops the angle side and waits until every predicted gain has been checked.
    // Each angle yields a gain, so an empty checker queue means the block is idle.
    task automatic wait_drained();
        angle_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] word);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_point(input int k, input int angle_q8, input int gain_q8);
        plan_angle[k] = ANGLE_W'(angle_q8);
        plan_gain[k]  = GAIN_W'(gain_q8);
    endtask

    // Writes every register from the plan. The unused upper bits of the count and
    // base words carry random junk, which the block has to ignore.
    task automatic program_table();
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom);
        word[SEG_W-1:0] = plan_count;
        write_reg(REG_SEGMENT_COUNT, word);
        word = CFG_DATA_W'($urandom);
        word[GAIN_W-1:0] = plan_base;
        write_reg(REG_BASE_GAIN, word);
        for (int k = 1; k <= NUM_POINT_REGS; k++)
            write_reg(REG_POINT1 + CFG_IDX_W'(k - 1), {plan_angle[k], plan_gain[k]});
        cfg_valid <= 1'b0;
    endtask

    // Most tables are well formed: rising angles inside 0..90 degrees. The rest are
    // unordered junk across the full 15-bit angle, or all-extreme corner tables.
    task automatic random_table();
        int kind;
        int cuts [$];
        kind = $urandom_range(9);
        for (int k = 1; k <= NUM_POINT_REGS; k++)
            cuts.push_back($urandom_range(FULL_SCALE));
        cuts.sort();
        for (int k = 1; k <= NUM_POINT_REGS; k++)
        begin
            if (kind < 7)
                set_point(k, cuts[k - 1], $urandom_range(GAIN_MAX));
            else if (kind < 9)
                set_point(k, $urandom_range(ANGLE_MAX), $urandom_range(GAIN_MAX));
            else
                set_point(k, ($urandom_range(1) != 0) ? ANGLE_MAX : 0,
                          ($urandom_range(1) != 0) ? GAIN_MAX : 0);
        end
        if (kind < 7 && $urandom_range(2) != 0)
            plan_count = SEG_W'(POINTS - 1);
        else
            plan_count = SEG_W'($urandom_range((1 << SEG_W) - 1));
        case ($urandom_range(7))
            0:       plan_base = '0;
            1:       plan_base = '1;
            default: plan_base = GAIN_W'($urandom);
        endcase
    endtask

    // Angles bunch around the breakpoints, where the search and the rounding are
    // most likely to go wrong, with the rest spread over and beyond 90 degrees.
    function automatic int pick_angle();
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 45)
            v = $urandom_range(FULL_SCALE);
        else if (r < 75)
            v = int'(plan_angle[$urandom_range(1, NUM_POINT_REGS)]) + int'($urandom_range(4)) - 2;
        else if (r < 88)
            v = $urandom_range(ANGLE_MAX);
        else if (r < 94)
            v = FULL_SCALE;
        else
            v = 0;
        if (v < 0)
            v = 0;
        if (v > ANGLE_MAX)
            v = ANGLE_MAX;
        return v;
    endfunction

    initial
    begin
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With the reset table only breakpoint 0 is in use, so any angle returns the
        // reset base gain.
        send_angle(0);
        send_angle(ANGLE_MAX);
        wait_drained();

        // Ordered table with full-swing gain steps in both directions. The last
        // breakpoint sits at the largest angle the field can hold, so 90 degrees
        // still interpolates and only the very top angle lands on the last gain.
        plan_count = SEG_W'(POINTS - 1);
        plan_base  = GAIN_W'(16'h0100);
        set_point(1, 3840, GAIN_MAX);
        set_point(2, 7680, 0);
        set_point(3, 11520, 16'h1234);
        set_point(4, 15360, 16'h0100);
        set_point(5, 19200, 16'h8000);
        set_point(6, ANGLE_MAX, 16'hABCD);
        program_table();
        foreach (ordered_probes[i])
            send_angle(ordered_probes[i]);
        wait_drained();

        // A count above the table is clamped to the last breakpoint. The breakpoints
        // are out of order and two share an angle, so the search has to skip over
        // lower entries that sit above higher ones.
        plan_count = '1;
        plan_base  = '1;
        set_point(1, 5000, 0);
        set_point(2, 5000, 16'h4000);
        set_point(3, 2000, 16'h7FFF);
        set_point(4, 20000, GAIN_MAX);
        set_point(5, 10000, 1);
        set_point(6, FULL_SCALE, 16'h0800);
        program_table();
        foreach (unordered_probes[i])
            send_angle(unordered_probes[i]);

        // Random phases, each with a fresh table loaded while the block is idle.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_drained();
            random_table();
            program_table();
            if (ph == CALM_PHASE)
                calm <= 1'b1;
            else if (ph == CALM_PHASE + 1)
                calm <= 1'b0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Part way through one phase the sender holds off until the
                // pipeline has emptied, then restarts from cold.
                if (ph == HOLD_PHASE && n == ITEMS_PER_PHASE / 2)
                    wait_drained();
                send_angle(pick_angle());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #5000000;
        $display("tb failed");
        $finish;
    end

endmodule
